// ===== hdl/scrf_pkg.sv =====
// Shared widths, access codes and register constants for the serial controller register file.
`default_nettype none

package scrf_pkg;

    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 8;
    localparam int CNT_W   = 32;
    localparam int PTR_W   = 4;
    localparam int NUM_CH  = 2;
    localparam int REGS_PER_CH = 1 << PTR_W;
    localparam int NUM_REGS    = NUM_CH * REGS_PER_CH;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);

    // offset bits that steer an access
    localparam int OFF_CH_BIT   = 1;
    localparam int OFF_DATA_BIT = 2;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic CH_A = 1'b1;
    localparam logic CH_B = 1'b0;

    localparam logic [PTR_W-1:0] PTR_RR0       = 4'd0;
    localparam logic [PTR_W-1:0] PTR_RR1       = 4'd1;
    localparam logic [PTR_W-1:0] PTR_RESET_REG = 4'd9;

    localparam logic [DATA_W-1:0] RR0_VALUE = 8'h04;
    localparam logic [DATA_W-1:0] RR1_VALUE = 8'h01;

    // reset command in bits 7-6 of register 9
    typedef enum logic [1:0] {
        RST_NONE  = 2'b00,
        RST_CH_B  = 2'b01,
        RST_CH_A  = 2'b10,
        RST_HW    = 2'b11
    } reset_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/serial_controller_register_file.sv =====
// Two-channel serial controller register file, bus side, one access per clock while the output is drained.
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------------
//  config    cfg_write_en         cfg_write_data (base address)
//  input     in_valid / in_ready  mode, bus_address, write_data
//  output    out_valid/out_ready  read_data, read_idle, tx_count, poll_count, write_count
//
// An access is captured in an input register and resolved into the result register
// when the result register is free or being drained, one access per cycle
// sustained while the output is drained. The result register is the only stall point;
// while it is held the input register holds one more access. Reset clears the
// pointers, all write registers and the counters at once.
`default_nettype none

module serial_controller_register_file #(
    parameter int ADDR_W = scrf_pkg::ADDR_W,
    parameter int DATA_W = scrf_pkg::DATA_W,
    parameter int CNT_W  = scrf_pkg::CNT_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_write_en,
    input  wire logic [ADDR_W-1:0] cfg_write_data,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              mode,
    input  wire logic [ADDR_W-1:0] bus_address,
    input  wire logic [DATA_W-1:0] write_data,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      read_data,
    output logic                   read_idle,
    output logic [CNT_W-1:0]       tx_count,
    output logic [CNT_W-1:0]       poll_count,
    output logic [CNT_W-1:0]       write_count
);

    localparam int PTR_W     = scrf_pkg::PTR_W;
    localparam int NUM_CH    = scrf_pkg::NUM_CH;
    localparam int NUM_REGS  = scrf_pkg::NUM_REGS;
    localparam int PER_CH    = scrf_pkg::REGS_PER_CH;
    localparam int IDX_W     = scrf_pkg::REG_IDX_W;

    logic [ADDR_W-1:0] base_reg;

    logic              in_vld_reg;
    logic              mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;

    logic [PTR_W-1:0]  ptr_reg  [NUM_CH];
    logic [PTR_W-1:0]  ptr_next [NUM_CH];
    logic [DATA_W-1:0] wr_reg   [NUM_REGS];
    logic [DATA_W-1:0] wr_next  [NUM_REGS];
    logic [CNT_W-1:0]  tx_reg, tx_next;
    logic [CNT_W-1:0]  poll_reg, poll_next;
    logic [CNT_W-1:0]  store_reg, store_next;

    logic              out_vld_reg;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic              idle_reg, idle_next;

    logic              advance;
    logic [ADDR_W-1:0] offset;
    logic              ch;
    logic              is_data;
    logic [PTR_W-1:0]  cur_ptr;
    logic [IDX_W-1:0]  reg_idx;
    scrf_pkg::reset_cmd_t rst_cmd;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    assign offset  = addr_reg - base_reg;
    assign ch      = offset[scrf_pkg::OFF_CH_BIT];
    assign is_data = offset[scrf_pkg::OFF_DATA_BIT];
    assign cur_ptr = ptr_reg[ch];
    assign reg_idx = {ch, cur_ptr};
    assign rst_cmd = scrf_pkg::reset_cmd_t'(wdata_reg[DATA_W-1 -: 2]);

    always_comb
    begin
        ptr_next   = ptr_reg;
        wr_next    = wr_reg;
        tx_next    = tx_reg;
        poll_next  = poll_reg;
        store_next = store_reg;
        rd_next    = '0;
        idle_next  = 1'b0;

        if (mode_reg == scrf_pkg::MODE_WRITE)
        begin
            if (is_data)
            begin
                tx_next = tx_reg + CNT_W'(1);
            end
            else if (cur_ptr == scrf_pkg::PTR_RR0)
            begin
                ptr_next[ch] = wdata_reg[PTR_W-1:0];
            end
            else
            begin
                ptr_next[ch]     = '0;
                wr_next[reg_idx] = wdata_reg;
                store_next       = store_reg + CNT_W'(1);
                if (cur_ptr == scrf_pkg::PTR_RESET_REG)
                begin
                    // a hardware reset, or a reset of the written channel, wipes the byte just stored as well
                    unique case (rst_cmd)
                        scrf_pkg::RST_HW:
                        begin
                            for (int i = 0; i < NUM_REGS; i++)
                                wr_next[i] = '0;
                            for (int c = 0; c < NUM_CH; c++)
                                ptr_next[c] = '0;
                        end
                        scrf_pkg::RST_CH_A:
                        begin
                            for (int i = 0; i < PER_CH; i++)
                                wr_next[int'(scrf_pkg::CH_A) * PER_CH + i] = '0;
                        end
                        scrf_pkg::RST_CH_B:
                        begin
                            for (int i = 0; i < PER_CH; i++)
                                wr_next[int'(scrf_pkg::CH_B) * PER_CH + i] = '0;
                        end
                        scrf_pkg::RST_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        else if (!is_data)
        begin
            ptr_next[ch] = '0;
            if (cur_ptr == scrf_pkg::PTR_RR0)
            begin
                poll_next = poll_reg + CNT_W'(1);
                rd_next   = scrf_pkg::RR0_VALUE;
            end
            else if (cur_ptr == scrf_pkg::PTR_RR1)
            begin
                rd_next = scrf_pkg::RR1_VALUE;
            end
            else
            begin
                rd_next = wr_reg[reg_idx];
            end
            idle_next = !rd_next[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            tx_reg      <= '0;
            poll_reg    <= '0;
            store_reg   <= '0;
            for (int c = 0; c < NUM_CH; c++)
                ptr_reg[c] <= '0;
            for (int i = 0; i < NUM_REGS; i++)
                wr_reg[i] <= '0;
        end
        else
        begin
            if (cfg_write_en)
                base_reg <= cfg_write_data;

            if (in_ready)
                in_vld_reg <= in_valid;

            if (advance)
            begin
                out_vld_reg <= 1'b1;
                ptr_reg     <= ptr_next;
                wr_reg      <= wr_next;
                tx_reg      <= tx_next;
                poll_reg    <= poll_next;
                store_reg   <= store_next;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg  <= mode;
            addr_reg  <= bus_address;
            wdata_reg <= write_data;
        end
        if (advance)
        begin
            rd_reg   <= rd_next;
            idle_reg <= idle_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign read_data   = rd_reg;
    assign read_idle   = idle_reg;
    assign tx_count    = tx_reg;
    assign poll_count  = poll_reg;
    assign write_count = store_reg;

endmodule

`default_nettype wire
